// File: sv/shell_zigzag_index_to_coord_core_assert.svh
// Assertion macros for the shell zigzag index-to-coordinate block.
// Both sample on clk and are switched off while rst is high.
`ifndef SHELL_ZIGZAG_INDEX_TO_COORD_CORE_ASSERT_SVH
`define SHELL_ZIGZAG_INDEX_TO_COORD_CORE_ASSERT_SVH

// Property holds at every sampled edge.
`define SZZ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("szz assertion failed");

// When pre holds, post holds in the next cycle.
`define SZZ_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("szz assertion failed");

`endif

// File: sv/szz_pkg.sv
// ----------------------------------------------------------------------------
// szz_pkg
// Shared widths and the item type carried down the square-root cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package szz_pkg;

  localparam int COORD_BITS = 24;
  localparam int INDEX_BITS = 2 * COORD_BITS;
  localparam int OUT_BITS   = COORD_BITS + 1;
  localparam int REM_BITS   = COORD_BITS + 2;

  // Partial square root of one item between two cells.
  typedef struct packed {
    logic [REM_BITS-1:0]   rem;   // running remainder
    logic [COORD_BITS-1:0] root;  // root digits found so far
    logic [INDEX_BITS-1:0] bits;  // index digits not yet consumed, msb-aligned
  } sqrt_item_t;

endpackage

`default_nettype wire

// File: sv/shell_zigzag_index_to_coord_core.sv
// ----------------------------------------------------------------------------
// shell_zigzag_index_to_coord_core
// Maps a 1-based square-shell zigzag index to its two coordinates.
//
//   channel  valid      stall      payload
//   req      req_valid  req_stall  index
//   rsp      rsp_valid  rsp_stall  first_coord, second_coord, invalid
//
// One item per cycle sustained while rsp_stall is low; 24 root cells, one digit
// each, then the coordinate stage and output register.
// Every cell holds its item until the next one frees, so bubbles close up
// and input is taken while a finished result waits on rsp_stall.
// Synchronous reset empties the chain; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module shell_zigzag_index_to_coord_core (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        req_valid,
  output logic                             req_stall,
  input  wire logic [szz_pkg::INDEX_BITS-1:0] index,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output logic [szz_pkg::OUT_BITS-1:0]     first_coord,
  output logic [szz_pkg::OUT_BITS-1:0]     second_coord,
  output logic                             invalid
);
  import szz_pkg::*;

  logic       link_valid [COORD_BITS+1];
  logic       link_ready [COORD_BITS+1];
  sqrt_item_t link_item  [COORD_BITS+1];

  assign link_valid[0]     = req_valid;
  assign link_item[0].rem  = '0;
  assign link_item[0].root = '0;
  assign link_item[0].bits = index;
  assign req_stall         = !link_ready[0];

  for (genvar i = 0; i < COORD_BITS; i++) begin : g_cell
    szz_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .up_valid (link_valid[i]),
      .up_item  (link_item[i]),
      .up_ready (link_ready[i]),
      .dn_valid (link_valid[i+1]),
      .dn_item  (link_item[i+1]),
      .dn_ready (link_ready[i+1])
    );
  end

  szz_finish u_finish (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (link_valid[COORD_BITS]),
    .up_item      (link_item[COORD_BITS]),
    .up_ready     (link_ready[COORD_BITS]),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .first_coord  (first_coord),
    .second_coord (second_coord),
    .invalid      (invalid)
  );

endmodule

`default_nettype wire

// File: sv/szz_cell.sv
// ----------------------------------------------------------------------------
// szz_cell
// One digit step of the integer square root, with its own item register.
// ----------------------------------------------------------------------------
`default_nettype none

module szz_cell (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               up_valid,
  input  wire szz_pkg::sqrt_item_t up_item,
  output logic                    up_ready,
  output logic                    dn_valid,
  output szz_pkg::sqrt_item_t     dn_item,
  input  wire logic               dn_ready
);
  import szz_pkg::*;

  logic                  valid;
  sqrt_item_t            item;
  sqrt_item_t            item_next;
  logic [REM_BITS-1:0]   rem_sh;
  logic [REM_BITS-1:0]   trial;
  logic                  take;

  // Bring down the next two index bits and try a one in the new root digit.
  always_comb begin
    rem_sh = {up_item.rem[REM_BITS-3:0], up_item.bits[INDEX_BITS-1 -: 2]};
    trial  = {up_item.root, 2'b01};
    take   = (rem_sh >= trial);
    item_next.rem  = take ? (rem_sh - trial) : rem_sh;
    item_next.root = {up_item.root[COORD_BITS-2:0], take};
    item_next.bits = {up_item.bits[INDEX_BITS-3:0], 2'b00};
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= item_next;
    end
  end

  assign dn_valid = valid;
  assign dn_item  = item;

endmodule

`default_nettype wire

// File: sv/szz_finish.sv
// ----------------------------------------------------------------------------
// szz_finish
// Turns the floor root and remainder into the shell, the offset and the two
// coordinates, and holds the result item for the output channel.
// ----------------------------------------------------------------------------
`default_nettype none

module szz_finish (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        up_valid,
  input  wire szz_pkg::sqrt_item_t          up_item,
  output logic                             up_ready,
  output logic                             rsp_valid,
  input  wire logic                        rsp_stall,
  output logic [szz_pkg::OUT_BITS-1:0]     first_coord,
  output logic [szz_pkg::OUT_BITS-1:0]     second_coord,
  output logic                             invalid
);
  import szz_pkg::*;

  localparam int DW = COORD_BITS + 3;

  logic                 valid;
  logic                 inexact;
  logic [OUT_BITS-1:0]  shell;
  logic [DW-1:0]        root_x;
  logic [DW-1:0]        rem_x;
  logic [DW-1:0]        diff;     // d - n, two's complement
  logic [DW-1:0]        gap;
  logic                 above;    // n > d
  logic                 below;    // n < d
  logic [OUT_BITS-1:0]  ofs;
  logic                 swap;
  logic                 zero_idx;
  logic [OUT_BITS-1:0]  first_next;
  logic [OUT_BITS-1:0]  second_next;

  // n = root^2 + rem. With rem != 0 the shell is root+1 and d - n = root+1-rem,
  // otherwise the shell is root and d - n = 1-root.
  always_comb begin
    inexact  = |up_item.rem;
    zero_idx = (up_item.root == '0);
    shell    = {1'b0, up_item.root} + OUT_BITS'(inexact);
    root_x   = DW'(up_item.root);
    rem_x    = DW'(up_item.rem);
    diff     = inexact ? (root_x + DW'(1) - rem_x) : (DW'(1) - root_x);
    above    = diff[DW-1];
    below    = !diff[DW-1] && (diff != '0);
    gap      = above ? (DW'(0) - diff) : diff;
    ofs      = shell - gap[OUT_BITS-1:0];
    swap     = shell[0] ? above : below;
    if (zero_idx) begin
      first_next  = '0;
      second_next = '0;
    end else if (swap) begin
      first_next  = ofs;
      second_next = shell;
    end else begin
      first_next  = shell;
      second_next = ofs;
    end
  end

  assign up_ready  = !valid || !rsp_stall;
  assign rsp_valid = valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      first_coord  <= first_next;
      second_coord <= second_next;
      invalid      <= zero_idx;
    end
  end

endmodule

`default_nettype wire

// File: sv/szz_check.sv
// ----------------------------------------------------------------------------
// szz_check
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "shell_zigzag_index_to_coord_core_assert.svh"

module szz_check (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        rsp_valid,
  input wire logic                        rsp_stall,
  input wire logic [szz_pkg::OUT_BITS-1:0] first_coord,
  input wire logic [szz_pkg::OUT_BITS-1:0] second_coord,
  input wire logic                        invalid
);
  import szz_pkg::*;

  // A stalled result item stays put.
  `SZZ_ASSERT_NEXT(a_hold, rsp_valid && rsp_stall, rsp_valid && $stable(first_coord) && $stable(second_coord) && $stable(invalid))

  // A zero index reports zero coordinates.
  `SZZ_ASSERT(a_zero, !(rsp_valid && invalid) || (first_coord == '0 && second_coord == '0))

  // Any real index lands on a 1-based cell.
  `SZZ_ASSERT(a_nonzero, !(rsp_valid && !invalid) || (first_coord != '0 && second_coord != '0))

endmodule

bind shell_zigzag_index_to_coord_core szz_check u_szz_check (.*);

`default_nettype wire

// File: verif/szz_coord_compare.sv
// ----------------------------------------------------------------------------
// szz_coord_compare
// Watches the req and rsp channels of the shell zigzag coordinate block,
// computes the coordinates of every accepted index and checks each accepted
// result against the oldest coordinates still due.
// ----------------------------------------------------------------------------
module szz_coord_compare (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           req_valid,
  input  logic                           req_stall,
  input  logic [szz_pkg::INDEX_BITS-1:0] index,
  input  logic                           rsp_valid,
  input  logic                           rsp_stall,
  input  logic [szz_pkg::OUT_BITS-1:0]   first_coord,
  input  logic [szz_pkg::OUT_BITS-1:0]   second_coord,
  input  logic                           invalid,
  output int                             failures,
  output int                             outstanding,
  output int                             results_checked
);
  timeunit 1ns;
  timeprecision 1ps;
  import szz_pkg::*;

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [INDEX_BITS-1:0] idx;
    logic [OUT_BITS-1:0]   first_c;
    logic [OUT_BITS-1:0]   second_c;
    logic                  inv;
  } shell_coord_t;

  shell_coord_t coords_due[$];
  int           fail_n = 0;
  int           seen_n = 0;

  // ceil(sqrt(n)) picks the shell; d = k*k-k+1 is where the shell turns
  function automatic shell_coord_t predict_coords(input logic [INDEX_BITS-1:0] n);
    shell_coord_t c;
    logic [63:0]  nn;
    logic [63:0]  root;
    logic [63:0]  trial;
    logic [63:0]  k;
    logic [63:0]  d;
    logic [63:0]  gap;
    logic [63:0]  ofs;
    nn    = 64'(n);
    c.idx = n;
    if (nn == 0) begin
      c.first_c  = '0;
      c.second_c = '0;
      c.inv      = 1'b1;
      return c;
    end
    root = 0;
    for (int b = COORD_BITS; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= nn) root = trial;
    end
    k    = (root * root < nn) ? root + 1 : root;
    d    = k * (k - 1) + 1;
    gap  = (nn > d) ? nn - d : d - nn;
    ofs  = k - gap;
    // odd shells put k second above the diagonal, even shells below it
    if (k[0] ? (nn > d) : (nn < d)) begin
      c.first_c  = OUT_BITS'(ofs);
      c.second_c = OUT_BITS'(k);
    end else begin
      c.first_c  = OUT_BITS'(k);
      c.second_c = OUT_BITS'(ofs);
    end
    c.inv = 1'b0;
    return c;
  endfunction

  always @(posedge clk) begin
    shell_coord_t want;
    if (rst) begin
      coords_due.delete();
    end else begin
      // drain before filling: a result never belongs to an index taken this cycle
      if (rsp_valid && !rsp_stall) begin
        seen_n++;
        if (coords_due.size() == 0) begin
          fail_n++;
          if (fail_n <= REPORT_LIMIT)
            $display("%0t: result (%0d,%0d,inv=%0b) with nothing due", $realtime,
                     first_coord, second_coord, invalid);
        end else begin
          want = coords_due.pop_front();
          if (first_coord !== want.first_c || second_coord !== want.second_c ||
              invalid !== want.inv) begin
            fail_n++;
            if (fail_n <= REPORT_LIMIT)
              $display("%0t: index %0d want (%0d,%0d,inv=%0b) got (%0d,%0d,inv=%0b)",
                       $realtime, want.idx, want.first_c, want.second_c, want.inv,
                       first_coord, second_coord, invalid);
          end
        end
      end
      if (req_valid && !req_stall) coords_due = {coords_due, predict_coords(index)};
    end
    failures        <= fail_n;
    outstanding     <= coords_due.size();
    results_checked <= seen_n;
  end

endmodule

// File: verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// Drives indices into shell_zigzag_index_to_coord_core: corner indices first,
// then a random mix of zero, small, full-width and shell-aligned indices, with
// random idling on both channels, a stretch without idling and one drained pause.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import szz_pkg::*;

  localparam int STALL_PCT      = 23;
  localparam int RANDOM_ITEMS   = 650;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 4 * (COORD_BITS + 1);
  localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
  localparam logic [63:0]           TOP_SHELL = 64'd1 << COORD_BITS;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic [INDEX_BITS-1:0] index     = '0;
  logic                  rsp_stall = 1'b0;
  logic                  calm      = 1'b0;
  logic                  req_stall;
  logic                  rsp_valid;
  logic [OUT_BITS-1:0]   first_coord;
  logic [OUT_BITS-1:0]   second_coord;
  logic                  invalid;

  int failures;
  int outstanding;
  int results_checked;
  int sent        = 0;
  int zeros_sent  = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  shell_zigzag_index_to_coord_core dut (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (req_valid),
    .req_stall    (req_stall),
    .index        (index),
    .rsp_valid    (rsp_valid),
    .rsp_stall    (rsp_stall),
    .first_coord  (first_coord),
    .second_coord (second_coord),
    .invalid      (invalid)
  );

  szz_coord_compare u_compare (
    .clk             (clk),
    .rst             (rst),
    .req_valid       (req_valid),
    .req_stall       (req_stall),
    .index           (index),
    .rsp_valid       (rsp_valid),
    .rsp_stall       (rsp_stall),
    .first_coord     (first_coord),
    .second_coord    (second_coord),
    .invalid         (invalid),
    .failures        (failures),
    .outstanding     (outstanding),
    .results_checked (results_checked)
  );

  always @(posedge clk) rsp_stall <= !calm && ($urandom_range(99) < STALL_PCT);

  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
      $display("shell_zigzag_index_to_coord_core test failed");
      $finish;
    end
  end

  // index at position pos within shell k, clipped to the index width
  function automatic logic [INDEX_BITS-1:0] shell_index(input logic [63:0] k,
                                                        input logic [63:0] pos);
    logic [63:0] n;
    n = (k - 1) * (k - 1) + 1 + pos;
    return (n > 64'(INDEX_MAX)) ? INDEX_MAX : INDEX_BITS'(n);
  endfunction

  function automatic logic [INDEX_BITS-1:0] random_index();
    int unsigned sel;
    int          w;
    logic [63:0] k;
    sel = $urandom_range(99);
    w   = $urandom_range(COORD_BITS, 1);
    k   = 64'($urandom) & ((64'd1 << w) - 1);
    if (k == 0) k = 1;
    if (sel < 5)       return '0;
    else if (sel < 30) return INDEX_BITS'($urandom_range(400, 1));
    else if (sel < 50) return INDEX_BITS'({$urandom, $urandom});
    else if (sel < 70) return shell_index(k, 64'($urandom_range(32'(2 * k - 2), 0)));
    else if (sel < 80) return shell_index(k, k - 1);
    else if (sel < 90) return shell_index(k, 0);
    else               return shell_index(k, 2 * k - 2);
  endfunction

  task automatic send_index(input logic [INDEX_BITS-1:0] v);
    while (!calm && $urandom_range(99) < STALL_PCT) begin
      req_valid <= 1'b0;
      index     <= INDEX_BITS'({$urandom, $urandom});
      @(posedge clk);
    end
    req_valid <= 1'b1;
    index     <= v;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
    if (v == 0) zeros_sent++;
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  initial begin
    logic [INDEX_BITS-1:0] corner[$];
    corner = '{'0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 12, 13, 14, 16, 17,
               INDEX_MAX, INDEX_MAX - 1,
               shell_index(TOP_SHELL, TOP_SHELL - 1),
               shell_index(TOP_SHELL, TOP_SHELL - 2),
               shell_index(TOP_SHELL, TOP_SHELL),
               shell_index(TOP_SHELL, 0),
               shell_index(TOP_SHELL - 1, 2 * TOP_SHELL - 4),
               shell_index(TOP_SHELL - 1, TOP_SHELL - 2)};
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (corner[i]) send_index(corner[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm <= (i >= 300 && i < 420);
      if (i == 200) wait_drained();
      send_index(random_index());
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d indices (%0d zero, corners of the top shell included),", sent,
             zeros_sent);
    $display("checked %0d results under random idling on both channels", results_checked);
    if (failures == 0 && outstanding == 0) begin
      $display("shell_zigzag_index_to_coord_core test passed");
    end else begin
      $display("shell_zigzag_index_to_coord_core test failed");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+sv
sv/szz_pkg.sv
sv/szz_cell.sv
sv/szz_finish.sv
sv/shell_zigzag_index_to_coord_core.sv
sv/szz_check.sv
verif/szz_coord_compare.sv
verif/tb.sv
